// File: rtl/lpcd_pkg.sv
// Shared types, character codes and helpers for the length-prefixed command deframer.
`default_nettype none

package lpcd_pkg;

   localparam int BYTE_W      = 8;
   localparam int ACC_W       = 50;
   localparam int DRIVE_W     = 51;
   localparam int SCEN_W      = 5;
   localparam int KIND_W      = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int TOKEN_DEPTH = 4;
   localparam int RSP_DEPTH   = 2;

   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;

   localparam logic [ACC_W-1:0]  MAX_MAGNITUDE = 50'd999999999999999;
   localparam logic [BYTE_W-1:0] SPEED_RESET   = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SPEED  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_SPEED = 8'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_THROTTLE = 3'd0,
      KIND_FREE     = 3'd1,
      KIND_START    = 3'd2,
      KIND_STOP     = 3'd3,
      KIND_ECHO     = 3'd4
   } kind_type;

   // One payload byte with its position flags, passed from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              second;
      logic              last;
   } token_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [DRIVE_W-1:0] drive;
      logic signed [SCEN_W-1:0]  scen;
      logic [BYTE_W-1:0]         echo;
   } rsp_type;

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

`default_nettype wire

// File: rtl/lpcd_fifo.sv
// Small register queue with occupancy count, used between pipeline parts.
`default_nettype none

module lpcd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lpcd_front.sv
// Header parser: reads the length prefix and tags payload bytes for the back end.
`default_nettype none

module lpcd_front #(
   parameter int PAYLOAD_BYTES = 16,
   parameter int LENGTH_DIGITS = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           rx_byte,
   output logic                      tok_push,
   output lpcd_pkg::token_type       tok
);

   import lpcd_pkg::*;

   localparam int LEN_W = $clog2(10 ** LENGTH_DIGITS);
   localparam int CNT_W = $clog2(LENGTH_DIGITS + 1);
   localparam int FL_W  = $clog2(PAYLOAD_BYTES + 1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_LEN  = 3'b010,
      PH_PAY  = 3'b100
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FL_W-1:0]  flen_ff, flen_in;
   logic [FL_W-1:0]  idx_ff, idx_in;
   logic [LEN_W+3:0] len_next;
   logic             len_ok;
   logic             last;

   // Decimal shift-in of one length digit
   assign len_next = {len_ff, 3'b000} + {3'b000, len_ff, 1'b0}
                   + (LEN_W + 4)'(rx_byte - CH_ZERO);
   assign len_ok   = (len_ff != '0) && (32'(len_ff) <= 32'(PAYLOAD_BYTES));
   assign last     = (FL_W'(idx_ff + 1'b1) == flen_ff);

   assign tok.data   = rx_byte;
   assign tok.first  = (idx_ff == '0);
   assign tok.second = (idx_ff == FL_W'(1));
   assign tok.last   = last;
   assign tok_push   = accept && (phase_ff == PH_PAY);

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      flen_in  = flen_ff;
      idx_in   = idx_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE, PH_LEN: begin
               priority if (phase_ff == PH_LEN && rx_byte == CH_CR) begin
                  flen_in = len_ok ? FL_W'(len_ff) : '0;
                  len_in  = '0;
                  cnt_in  = '0;
               end else if (phase_ff == PH_LEN && rx_byte == CH_LF) begin
                  if (flen_ff != '0) begin
                     phase_in = PH_PAY;
                     idx_in   = '0;
                  end else begin
                     phase_in = PH_IDLE;
                     len_in   = '0;
                     cnt_in   = '0;
                     flen_in  = '0;
                     idx_in   = '0;
                  end
               end else if (is_digit(rx_byte)) begin
                  phase_in = PH_LEN;
                  if (cnt_ff < CNT_W'(LENGTH_DIGITS)) begin
                     len_in = LEN_W'(len_next);
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  phase_in = phase_ff;
               end
            end
            PH_PAY: begin
               if (last) begin
                  phase_in = PH_IDLE;
                  len_in   = '0;
                  cnt_in   = '0;
                  flen_in  = '0;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         cnt_ff   <= '0;
         flen_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         flen_ff  <= flen_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lpcd_back.sv
// Command executor: accumulates the payload and builds the result at frame end.
`default_nettype none

module lpcd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lpcd_pkg::token_type tok,
   input  wire logic                tok_empty,
   output logic                     tok_pop,
   input  wire logic [7:0]          first_speed,
   input  wire logic [7:0]          second_speed,
   output lpcd_pkg::rsp_type        rsp,
   output logic                     rsp_push,
   input  wire logic                rsp_full
);

   import lpcd_pkg::*;

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] scen_ff, scen_in;
   logic              done_ff, done_in;
   logic [ACC_W+3:0]  prod;
   logic [3:0]        scen_num;
   logic [SCEN_W-1:0] scen_idx;
   logic [DRIVE_W-1:0] mag;

   // Hold the token queue while a finished result cannot leave
   assign tok_pop  = !tok_empty && !(done_ff && rsp_full);
   assign rsp_push = done_ff && !rsp_full;

   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
               + (ACC_W + 4)'(tok.data - CH_ZERO);

   always_comb begin
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      cmd_in  = cmd_ff;
      scen_in = scen_ff;
      if (tok_pop) begin
         if (tok.first) begin
            cmd_in  = tok.data;
            scen_in = '0;
            acc_in  = '0;
            neg_in  = 1'b0;
         end else begin
            if (tok.second) begin
               scen_in = tok.data;
            end
            if (is_digit(tok.data)) begin
               acc_in = (prod > (ACC_W + 4)'(MAX_MAGNITUDE)) ? MAX_MAGNITUDE
                                                            : ACC_W'(prod);
            end else if (tok.data == CH_MINUS) begin
               neg_in = !neg_ff;
            end
         end
      end
      priority if (tok_pop && tok.last) begin
         done_in = 1'b1;
      end else if (rsp_push) begin
         done_in = 1'b0;
      end else begin
         done_in = done_ff;
      end
   end

   // Result build from the settled frame registers
   assign scen_num = is_digit(scen_ff) ? 4'(scen_ff - CH_ZERO) : 4'd0;
   assign scen_idx = {1'b0, scen_num} - SCEN_W'(1);
   assign mag      = {1'b0, acc_ff};

   always_comb begin
      rsp.kind  = KIND_ECHO;
      rsp.drive = '0;
      rsp.scen  = '1;
      rsp.echo  = '0;
      unique case (cmd_ff)
         CH_T: begin
            rsp.kind  = KIND_THROTTLE;
            rsp.drive = neg_ff ? (~mag + 1'b1) : mag;
         end
         CH_F: begin
            rsp.kind = KIND_FREE;
         end
         CH_S: begin
            rsp.scen = scen_idx;
            priority if (scen_idx == SCEN_W'(0)) begin
               rsp.kind  = KIND_START;
               rsp.drive = DRIVE_W'(first_speed);
            end else if (scen_idx == SCEN_W'(1)) begin
               rsp.kind  = KIND_START;
               rsp.drive = DRIVE_W'(second_speed);
            end else begin
               rsp.kind = KIND_STOP;
            end
         end
         default: begin
            rsp.kind = KIND_ECHO;
            rsp.echo = cmd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      cmd_ff  <= cmd_in;
      scen_ff <= scen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/length_prefixed_command_deframer_core.sv
// Top level of the length-prefixed command deframer: front, token queue, back, result queue.
`default_nettype none

// Channel    Handshake            Payload                              Direction
// req        push / full          req_rx_byte                          in
// rsp        pop / empty          rsp_command_kind, rsp_drive_value,   out
//                                 rsp_scenario_index, rsp_echo_byte
// csr        csr_valid/csr_ready  csr_index, csr_wdata                 in
//
// One byte is taken per cycle; full rises only when the four-entry token queue
// between the header parser and the executor is occupied.
// A result passes the token queue and the executor's registers before it enters
// the result queue, and is visible while empty is low.
// A stalled result side fills the two-entry result queue, then the token queue,
// then raises full. Synchronous reset returns everything to idle; both
// scenario speeds reset to 255. csr_ready is always high.

module length_prefixed_command_deframer_core #(
   parameter int PAYLOAD_BYTES = 16,
   parameter int LENGTH_DIGITS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_rx_byte,
   // result output
   input  wire logic        pop,
   output logic             empty,
   output logic [2:0]       rsp_command_kind,
   output logic signed [50:0] rsp_drive_value,
   output logic signed [4:0]  rsp_scenario_index,
   output logic [7:0]       rsp_echo_byte,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   import lpcd_pkg::*;

   logic              accept;
   logic              tok_push;
   token_type         tok_wr, tok_rd;
   logic              tok_empty, tok_pop;
   rsp_type           rsp_wr, rsp_rd;
   logic              rsp_push, rsp_full;
   logic [BYTE_W-1:0] speed1_ff, speed1_in;
   logic [BYTE_W-1:0] speed2_ff, speed2_in;

   assign accept    = push && !full;
   assign csr_ready = 1'b1;

   // Register writes; an index beyond the list is dropped
   always_comb begin
      speed1_in = speed1_ff;
      speed2_in = speed2_ff;
      if (csr_valid && csr_ready) begin
         priority if (csr_index == CSR_FIRST_SPEED) begin
            speed1_in = csr_wdata;
         end else if (csr_index == CSR_SECOND_SPEED) begin
            speed2_in = csr_wdata;
         end else begin
            speed1_in = speed1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed1_ff <= SPEED_RESET;
         speed2_ff <= SPEED_RESET;
      end else begin
         speed1_ff <= speed1_in;
         speed2_ff <= speed2_in;
      end
   end

   // Header parsing and tagging of payload bytes
   lpcd_front #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .LENGTH_DIGITS (LENGTH_DIGITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .tok_push (tok_push),
      .tok      (tok_wr)
   );

   // Token queue decoupling the parser from the executor
   lpcd_fifo #(
      .WIDTH ($bits(token_type)),
      .DEPTH (TOKEN_DEPTH)
   ) u_tok_fifo (
      .clock (clock),
      .reset (reset),
      .push  (tok_push),
      .wdata (tok_wr),
      .full  (full),
      .pop   (tok_pop),
      .rdata (tok_rd),
      .empty (tok_empty)
   );

   // Accumulation and result build
   lpcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tok          (tok_rd),
      .tok_empty    (tok_empty),
      .tok_pop      (tok_pop),
      .first_speed  (speed1_ff),
      .second_speed (speed2_ff),
      .rsp          (rsp_wr),
      .rsp_push     (rsp_push),
      .rsp_full     (rsp_full)
   );

   // Result queue: holds finished results while the consumer stalls
   lpcd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rd),
      .empty (empty)
   );

   assign rsp_command_kind   = rsp_rd.kind;
   assign rsp_drive_value    = rsp_rd.drive;
   assign rsp_scenario_index = rsp_rd.scen;
   assign rsp_echo_byte      = rsp_rd.echo;

   // The executor never offers a result to a full result queue
   a_rsp_no_overflow : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full result queue");

   // Tokens are only taken when present
   a_tok_pop_valid : assert property (@(posedge clock) disable iff (reset)
      tok_pop |-> !tok_empty)
      else $error("token popped from empty queue");

   // A scenario start always names scenario one or two
   a_start_index : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_command_kind == KIND_START) |->
         (rsp_scenario_index == 5'sd0 || rsp_scenario_index == 5'sd1))
      else $error("scenario start with index outside one and two");

   // Reset leaves both queues empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule

`default_nettype wire

// File: sim/length_prefixed_command_deframer_core_tb.sv
// Self-checking testbench for the length-prefixed command deframer core.
`timescale 1ns / 1ps

module length_prefixed_command_deframer_core_tb;
   import lpcd_pkg::*;

   localparam int PAYLOAD_MAX    = 16;
   localparam int LEN_DIGITS_MAX = 3;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_BYTES    = 140;

   // first register index that the block has no register behind
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 8'd2;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_LENGTH  = 3'b010,
      ST_PAYLOAD = 3'b100
   } deframe_state_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic [7:0]                req_rx_byte = '0;
   logic                      pop = 1'b0;
   logic                      empty;
   logic [2:0]                rsp_command_kind;
   logic signed [50:0]        rsp_drive_value;
   logic signed [4:0]         rsp_scenario_index;
   logic [7:0]                rsp_echo_byte;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [7:0]                csr_wdata = '0;

   // stimulus and expectation stores
   logic [7:0]                pending_rx_bytes[$];
   rsp_type                   expected_commands[$];
   int                        bytes_queued = 0;
   int                        mismatch_count = 0;
   int                        req_gap = 0;
   int                        rsp_stall = 0;
   int                        quiet_cycles = 0;
   bit                        req_idle_on = 1'b1;
   bit                        rsp_idle_on = 1'b1;

   // predictor state, mirrors the deframer from the byte stream alone
   logic [BYTE_W-1:0]         first_speed = SPEED_RESET;
   logic [BYTE_W-1:0]         second_speed = SPEED_RESET;
   deframe_state_type         hdr_state;
   logic [3:0]                held_digit [LEN_DIGITS_MAX];
   int                        digits_held;
   int                        payload_len;
   int                        payload_pos;
   logic [BYTE_W-1:0]         opcode_byte;
   logic [BYTE_W-1:0]         scen_byte;
   logic [63:0]               throttle_mag;
   logic                      throttle_neg;

   length_prefixed_command_deframer_core #(
      .PAYLOAD_BYTES (PAYLOAD_MAX),
      .LENGTH_DIGITS (LEN_DIGITS_MAX)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_rx_byte        (req_rx_byte),
      .pop                (pop),
      .empty              (empty),
      .rsp_command_kind   (rsp_command_kind),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_scenario_index (rsp_scenario_index),
      .rsp_echo_byte      (rsp_echo_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic void clear_frame();
      int i;
      hdr_state    = ST_IDLE;
      for (i = 0; i < LEN_DIGITS_MAX; i++) held_digit[i] = '0;
      digits_held  = 0;
      payload_len  = 0;
      payload_pos  = 0;
      opcode_byte  = '0;
      scen_byte    = '0;
      throttle_mag = '0;
      throttle_neg = 1'b0;
   endfunction

   function automatic bit is_decimal(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   // Advance the mirrored deframer by one accepted byte; queue a command when
   // the byte closes a frame.
   task automatic predict_rx_byte(input logic [7:0] b);
      int          i;
      int          header_len;
      int          scen_num;
      logic [63:0] digit_val;
      logic [50:0] magnitude;
      rsp_type     cmd;

      if (hdr_state != ST_PAYLOAD) begin
         if (hdr_state == ST_LENGTH && b == CH_CR) begin
            // CR evaluates the digits held and clears them
            header_len = 0;
            for (i = 0; i < digits_held; i++) header_len = header_len * 10 + held_digit[i];
            for (i = 0; i < LEN_DIGITS_MAX; i++) held_digit[i] = '0;
            digits_held = 0;
            payload_len = (header_len >= 1 && header_len <= PAYLOAD_MAX) ? header_len : 0;
         end else if (hdr_state == ST_LENGTH && b == CH_LF) begin
            if (payload_len >= 1 && payload_len <= PAYLOAD_MAX) begin
               hdr_state   = ST_PAYLOAD;
               payload_pos = 0;
            end else begin
               clear_frame();
            end
         end else if (is_decimal(b)) begin
            hdr_state = ST_LENGTH;
            // drop digits beyond the header width
            if (digits_held < LEN_DIGITS_MAX) begin
               held_digit[digits_held] = 4'(b - CH_ZERO);
               digits_held++;
            end
         end
      end else begin
         if (payload_pos == 0) begin
            opcode_byte  = b;
            scen_byte    = '0;
            throttle_mag = '0;
            throttle_neg = 1'b0;
         end else begin
            if (payload_pos == 1) scen_byte = b;
            if (is_decimal(b)) begin
               digit_val = 64'(b - CH_ZERO);
               // saturate the magnitude rather than wrap
               if (throttle_mag > (64'(MAX_MAGNITUDE) - digit_val) / 10)
                  throttle_mag = 64'(MAX_MAGNITUDE);
               else
                  throttle_mag = throttle_mag * 10 + digit_val;
            end else if (b == CH_MINUS) begin
               throttle_neg = ~throttle_neg;
            end
         end
         payload_pos++;

         if (payload_pos >= payload_len) begin
            cmd.drive = '0;
            cmd.scen  = '1;
            cmd.echo  = '0;
            if (opcode_byte == CH_T) begin
               cmd.kind  = KIND_THROTTLE;
               magnitude = throttle_mag[50:0];
               cmd.drive = throttle_neg ? (51'd0 - magnitude) : magnitude;
            end else if (opcode_byte == CH_F) begin
               cmd.kind = KIND_FREE;
            end else if (opcode_byte == CH_S) begin
               // only the second payload byte names the scenario
               scen_num = is_decimal(scen_byte) ? int'(scen_byte - CH_ZERO) : 0;
               cmd.scen = SCEN_W'(scen_num - 1);
               if (scen_num == 1) begin
                  cmd.kind  = KIND_START;
                  cmd.drive = {{(DRIVE_W-BYTE_W){1'b0}}, first_speed};
               end else if (scen_num == 2) begin
                  cmd.kind  = KIND_START;
                  cmd.drive = {{(DRIVE_W-BYTE_W){1'b0}}, second_speed};
               end else begin
                  cmd.kind = KIND_STOP;
               end
            end else begin
               cmd.kind = KIND_ECHO;
               cmd.echo = opcode_byte;
            end
            expected_commands.push_back(cmd);
            clear_frame();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Byte driver and result monitor
   // ---------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Hold a byte until its transfer, then idle for the chosen gap before the next.
   always @(posedge clock) begin
      if (reset) begin
         push    <= 1'b0;
         req_gap <= 0;
      end else begin
         if (push && !full) predict_rx_byte(req_rx_byte);
         if (!push || !full) begin
            if (req_gap > 0) begin
               push    <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_rx_bytes.size() != 0) begin
               push        <= 1'b1;
               req_rx_byte <= pending_rx_bytes.pop_front();
               req_gap     <= pick_gap(req_idle_on);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   task automatic check_result();
      rsp_type want;
      if (expected_commands.size() == 0) begin
         $error("result with no command expected: kind %0d drive %0d", rsp_command_kind,
                rsp_drive_value);
         mismatch_count++;
      end else begin
         want = expected_commands.pop_front();
         if (rsp_command_kind !== want.kind) begin
            $error("command_kind: expected %0d, got %0d", want.kind, rsp_command_kind);
            mismatch_count++;
         end
         if (rsp_drive_value !== want.drive) begin
            $error("drive_value: expected %0d, got %0d", want.drive, rsp_drive_value);
            mismatch_count++;
         end
         if (rsp_scenario_index !== want.scen) begin
            $error("scenario_index: expected %0d, got %0d", want.scen, rsp_scenario_index);
            mismatch_count++;
         end
         if (rsp_echo_byte !== want.echo) begin
            $error("echo_byte: expected 0x%02h, got 0x%02h", want.echo, rsp_echo_byte);
            mismatch_count++;
         end
      end
   endtask

   // Pop whenever not stalling; a stall starts after each result transfer.
   always @(posedge clock) begin : result_monitor
      int stall;
      if (reset) begin
         pop       <= 1'b0;
         rsp_stall <= 0;
      end else begin
         stall = rsp_stall;
         if (pop && !empty) begin
            check_result();
            stall = pick_gap(rsp_idle_on);
         end else if (stall > 0) begin
            stall = stall - 1;
         end
         rsp_stall <= stall;
         pop       <= (stall == 0);
      end
   end

   // Abort when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transfer for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] b);
      pending_rx_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic int decimal_width(input int n);
      return (n < 10) ? 1 : (n < 100) ? 2 : 3;
   endfunction

   // Zero-padded decimal, most significant digit first.
   task automatic send_digits(input int n, input int width);
      int k;
      int scale;
      for (k = width - 1; k >= 0; k--) begin
         scale = 1;
         repeat (k) scale = scale * 10;
         send_byte(8'(CH_ZERO + (n / scale) % 10));
      end
   endtask

   task automatic send_header(input int n, input int width);
      send_digits(n, width);
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // Any byte the header parser skips over.
   function automatic logic [7:0] pick_filler();
      logic [7:0] b;
      do b = 8'($urandom);
      while (is_decimal(b) || b == CH_CR || b == CH_LF);
      return b;
   endfunction

   task automatic send_payload(input int len);
      int         i;
      int         r;
      logic [7:0] opcode;
      r = $urandom_range(0, 99);
      if (r < 35)      opcode = CH_T;
      else if (r < 60) opcode = CH_S;
      else if (r < 70) opcode = CH_F;
      else             opcode = 8'($urandom);
      send_byte(opcode);
      for (i = 1; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (opcode == CH_S && i == 1) begin
            // favour the two scenarios that start
            if (r < 40)      send_byte(8'(CH_ZERO + $urandom_range(1, 2)));
            else if (r < 85) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            else             send_byte(8'($urandom));
         end else if (opcode == CH_T) begin
            if (r < 70)      send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            else if (r < 85) send_byte(CH_MINUS);
            else             send_byte(8'($urandom));
         end else begin
            if (r < 30) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            else        send_byte(8'($urandom));
         end
      end
   endtask

   // Mostly well-formed frames with random content, the rest broken headers
   // and raw noise.
   task automatic send_random_frame();
      int len;
      int n;
      len = $urandom_range(1, PAYLOAD_MAX);
      if ($urandom_range(0, 7) == 0) send_byte(pick_filler());
      if ($urandom_range(0, 99) < 80) begin
         send_header(len, $urandom_range(decimal_width(len), LEN_DIGITS_MAX));
         send_payload(len);
      end else begin
         case ($urandom_range(0, 6))
            0: send_header(0, $urandom_range(1, LEN_DIGITS_MAX));
            1: begin
               n = $urandom_range(PAYLOAD_MAX + 1, 999);
               send_header(n, decimal_width(n));
            end
            2: begin
               send_digits(len, decimal_width(len));
               send_byte(CH_LF);
            end
            3: begin
               send_digits(len, decimal_width(len));
               send_byte(CH_CR);
               send_byte(CH_CR);
               send_byte(CH_LF);
            end
            4: begin
               // surplus digit past the header width is dropped
               send_digits(len, LEN_DIGITS_MAX);
               send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
               send_byte(CH_CR);
               send_byte(CH_LF);
               send_payload(len);
            end
            5: repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            default: begin
               send_byte(8'(CH_ZERO + len / 10));
               send_byte(pick_filler());
               send_byte(8'(CH_ZERO + len % 10));
               send_byte(CH_CR);
               send_byte(CH_LF);
               send_payload(len);
            end
         endcase
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_FIRST_SPEED)
         first_speed = value;
      else if (index == CSR_SECOND_SPEED)
         second_speed = value;
   endtask

   // Wait for every byte and result to pass, then let the pipeline settle.
   task automatic wait_until_idle();
      @(negedge clock);
      while (pending_rx_bytes.size() != 0 || push || expected_commands.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------

   initial begin : stimulus
      int         phase_no;
      int         target;
      int         i;
      logic [7:0] speed_a;
      logic [7:0] speed_b;

      clear_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames at the reset speeds.
      // CR, LF and non-digits while idle are skipped
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(1, 1);
      send_byte(CH_F);
      send_header(2, 1);
      send_text("S1");
      send_header(2, 2);
      send_text("S2");
      send_header(2, 1);
      send_text("S0");
      send_header(2, 3);
      send_text("S9");
      // one-byte scenario command and non-digit scenario byte both stop
      send_header(1, 1);
      send_byte(CH_S);
      send_header(3, 1);
      send_byte(CH_S);
      send_byte(8'hFF);
      send_text("1");
      // largest magnitude positive, then a negative value one digit shorter
      send_header(PAYLOAD_MAX, 2);
      send_byte(CH_T);
      for (i = 1; i < PAYLOAD_MAX; i++) send_byte(CH_NINE);
      send_header(PAYLOAD_MAX, 3);
      send_byte(CH_T);
      send_byte(CH_MINUS);
      for (i = 2; i < PAYLOAD_MAX; i++) send_byte(CH_NINE);
      send_header(6, 1);
      send_text("T-1-2-");
      send_header(1, 1);
      send_byte(CH_T);
      // unknown commands echo their first byte
      send_header(1, 1);
      send_byte(8'hFF);
      send_header(2, 1);
      send_byte(8'h00);
      send_byte(8'hFF);
      // fourth length digit ignored: "0013" means one byte
      send_text("0013");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_F);
      // lengths out of range are dropped
      send_header(PAYLOAD_MAX + 1, 2);
      send_header(999, 3);
      send_header(0, 1);
      // repeated CR reads zero, LF alone finds no length
      send_text("5");
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_text("4");
      send_byte(CH_LF);
      // filler between length digits, then a new length after CR
      send_text("1");
      send_byte(8'hFF);
      send_text("0");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_text("T12345abc9");
      send_text("9");
      send_byte(CH_CR);
      send_text("3");
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_text("F12");
      wait_until_idle();

      // Random phases, each with its own speeds and idling mix.
      for (phase_no = 1; phase_no <= RANDOM_PHASES; phase_no++) begin
         case (phase_no)
            1: begin
               speed_a = '0;
               speed_b = '1;
            end
            2: begin
               speed_a = '1;
               speed_b = '0;
            end
            3: begin
               speed_a = '0;
               speed_b = '0;
            end
            default: begin
               speed_a = 8'($urandom);
               speed_b = 8'($urandom);
            end
         endcase
         write_register(CSR_FIRST_SPEED, speed_a);
         write_register(CSR_SECOND_SPEED, speed_b);
         // writes to unmapped indexes must change nothing
         write_register(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, {CSR_INDEX_W{1'b1}})),
                        8'($urandom));
         req_idle_on = (phase_no % 3 != 1);
         rsp_idle_on = (phase_no % 3 != 2);
         @(negedge clock);
         target = bytes_queued + PHASE_BYTES;
         while (bytes_queued < target) send_random_frame();
         wait_until_idle();
      end

      if (mismatch_count == 0 && expected_commands.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
